// ===== rtl/u2mr_pkg.sv =====
// Shared types, constants and code point mapping functions for the UTF-8 to Mac Roman converter.
package u2mr_pkg;

    // Code emitted for anything that has no Mac Roman equivalent.
    localparam logic [7:0] SPACE_CODE = 8'h20;

    // Default depth of the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Lead byte classes.
    localparam logic [2:0] LEAD2_MARK = 3'b110;
    localparam logic [3:0] LEAD3_MARK = 4'b1110;

    // Command handed from the front to the back.
    // A double command emits a space first, then code with the last mark set.
    typedef struct packed {
        logic       dbl;
        logic       last;
        logic [7:0] code;
    } cmd_t;

    // State of sequence assembly in the front.
    typedef enum logic [1:0] {
        HOLD_NONE   = 2'd0,
        HOLD_LEAD   = 2'd1,
        HOLD_SECOND = 2'd2
    } hold_t;

    // Map a two-byte sequence to its Mac Roman code.
    function automatic logic [7:0] map_two(input logic [7:0] lead, input logic [7:0] cont);
        logic [10:0] cp;
        cp = {lead[4:0], cont[5:0]};
        if (cp == 11'h0A7)
            map_two = 8'hA4;
        else if (cp == 11'h0A9)
            map_two = 8'hA9;
        else if (cp == 11'h0AE)
            map_two = 8'hA8;
        else if (cp >= 11'h0C0 && cp <= 11'h0FF)
            map_two = cp[7:0];
        else
            map_two = SPACE_CODE;
    endfunction

    // Map a three-byte sequence to its Mac Roman code.
    function automatic logic [7:0] map_three(input logic [7:0] lead, input logic [7:0] b2,
                                             input logic [7:0] b3);
        logic [15:0] cp;
        cp = {lead[3:0], b2[5:0], b3[5:0]};
        if (cp == 16'h2018 || cp == 16'h2019)
            map_three = 8'hD5;
        else if (cp == 16'h201C || cp == 16'h201D)
            map_three = 8'hD2;
        else if (cp == 16'h2013)
            map_three = 8'hD6;
        else if (cp == 16'h2014)
            map_three = 8'hD7;
        else if (cp == 16'h2022)
            map_three = 8'hA5;
        else if (cp == 16'h2026)
            map_three = 8'hC9;
        else
            map_three = SPACE_CODE;
    endfunction

endpackage

// ===== rtl/u2mr_front.sv =====
// Front end: accepts UTF-8 bytes, assembles sequences and issues output commands.
module u2mr_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                in_ready,
    input  logic                space_ok,
    output logic                push,
    output u2mr_pkg::cmd_t      cmd
);

    logic [7:0]      lead_reg,   lead_next;
    logic [7:0]      second_reg, second_next;
    u2mr_pkg::hold_t hold_reg,   hold_next;
    logic            accept;
    logic            is_two;
    logic            is_lead;

    assign in_ready = space_ok;
    assign accept   = in_valid & space_ok;
    assign is_two   = (lead_reg[7:5] == u2mr_pkg::LEAD2_MARK);
    assign is_lead  = (in_byte[7:5] == u2mr_pkg::LEAD2_MARK) ||
                      (in_byte[7:4] == u2mr_pkg::LEAD3_MARK);

    // Hold state and lead bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= u2mr_pkg::HOLD_NONE;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lead_reg   <= lead_next;
        second_reg <= second_next;
    end

    // Classify the incoming byte against what is held.
    always_comb
    begin
        hold_next   = hold_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        push        = 1'b0;
        cmd         = '{dbl: 1'b0, last: in_last, code: u2mr_pkg::SPACE_CODE};
        if (accept)
        begin
            unique case (hold_reg)
                u2mr_pkg::HOLD_LEAD:
                begin
                    if (is_two)
                    begin
                        hold_next = u2mr_pkg::HOLD_NONE;
                        push      = 1'b1;
                        cmd.code  = u2mr_pkg::map_two(lead_reg, in_byte);
                    end
                    else if (in_last)
                    begin
                        // Three-byte sequence cut short by the last byte.
                        hold_next = u2mr_pkg::HOLD_NONE;
                        push      = 1'b1;
                        cmd.dbl   = 1'b1;
                        cmd.code  = in_byte[7] ? u2mr_pkg::SPACE_CODE : in_byte;
                    end
                    else
                    begin
                        second_next = in_byte;
                        hold_next   = u2mr_pkg::HOLD_SECOND;
                    end
                end
                u2mr_pkg::HOLD_SECOND:
                begin
                    hold_next = u2mr_pkg::HOLD_NONE;
                    push      = 1'b1;
                    cmd.code  = u2mr_pkg::map_three(lead_reg, second_reg, in_byte);
                end
                default:
                begin
                    hold_next = u2mr_pkg::HOLD_NONE;
                    if (!in_byte[7])
                    begin
                        push     = 1'b1;
                        cmd.code = in_byte;
                    end
                    else if (is_lead && !in_last)
                    begin
                        lead_next = in_byte;
                        hold_next = u2mr_pkg::HOLD_LEAD;
                    end
                    else
                    begin
                        // Stray byte, four-byte lead, or a lead on the last byte.
                        push = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/u2mr_queue.sv =====
// Small command queue that decouples the front end from the output stage.
module u2mr_queue
#(
    parameter int unsigned DEPTH = u2mr_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  u2mr_pkg::cmd_t push_cmd,
    output logic           space_ok,
    input  logic           pop,
    output logic           not_empty,
    output u2mr_pkg::cmd_t head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u2mr_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign space_ok  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/u2mr_back.sv =====
// Back end: expands queued commands into output transfers through an output register.
module u2mr_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           not_empty,
    input  u2mr_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           out_valid,
    output logic [7:0]     out_byte,
    output logic           out_last,
    input  logic           out_ready
);

    logic       valid_reg,  valid_next;
    logic [7:0] byte_reg,   byte_next;
    logic       last_reg,   last_next;
    logic       phase_reg,  phase_next;
    logic       load;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign load      = !valid_reg || out_ready;

    // Select the next output; a double command stays at the head for two transfers.
    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = not_empty;
            if (not_empty)
            begin
                if (head_cmd.dbl && !phase_reg)
                begin
                    byte_next  = u2mr_pkg::SPACE_CODE;
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end
                else
                begin
                    byte_next  = head_cmd.code;
                    last_next  = head_cmd.last;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/utf8_to_mac_roman_converter.sv =====
// Top level of the UTF-8 to Mac Roman converter: front end, command queue and output stage.
// Throughput: one input byte per cycle while the command queue has space; a truncated
// three-byte sequence yields two output transfers, which the command queue absorbs.
// An accepted completing byte reaches its output transfer through a front-to-queue
// write, then the output register load.
// Reset: rst_n is asynchronous, active low; it clears the hold state, the queue and
// the output valid.
module utf8_to_mac_roman_converter
#(
    parameter int unsigned QUEUE_DEPTH = u2mr_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    logic           space_ok;
    logic           push;
    logic           pop;
    logic           not_empty;
    u2mr_pkg::cmd_t push_cmd;
    u2mr_pkg::cmd_t head_cmd;

    u2mr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .space_ok (space_ok),
        .push     (push),
        .cmd      (push_cmd)
    );

    u2mr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .space_ok  (space_ok),
        .pop       (pop),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    u2mr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready)
    );

endmodule

// ===== rtl/u2mr_checker.sv =====
// Port-level checker for the UTF-8 to Mac Roman converter, with its bind statement.
module u2mr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // A stalled output transfer stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled output transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // Codes 0x80 to 0xBF only come from the mapped symbols.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7:6] == 2'b10 |->
            m_axis_tdata == 8'hA4 || m_axis_tdata == 8'hA5 ||
            m_axis_tdata == 8'hA8 || m_axis_tdata == 8'hA9)
        else $error("unexpected output code in the continuation range");

    // Nothing is offered right after reset is released.
    assert property (@(posedge clk) $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid high coming out of reset");

    // The input side is open right after reset, since the queue starts empty.
    assert property (@(posedge clk) $rose(rst_n) |-> s_axis_tready)
        else $error("input ready low coming out of reset");

endmodule

bind utf8_to_mac_roman_converter u2mr_checker u_checker (.*);
